/* sv/tts_pkg.sv */
// Shared types and constants for the TFTP transfer session block.
// Holds the packet-kind, reply and phase codes and the beat structs.
// No dependencies.
package tts_pkg;

    // Field widths
    localparam int BLK_W = 16;
    localparam int LEN_W = 10;

    // Largest block payload in bytes; a shorter block ends the transfer
    localparam int BLOCK_BYTES = 512;

    // Received packet kinds (codes 6 and 7 mean nothing)
    typedef enum logic [2:0] {
        ACT_RRQ   = 3'd0,
        ACT_WRQ   = 3'd1,
        ACT_DATA  = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_ERROR = 3'd4,
        ACT_OTHER = 3'd5
    } t_action;

    // Reply packet kinds
    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Error codes carried by an error reply
    typedef enum logic [1:0] {
        EC_ILLEGAL  = 2'd0,
        EC_NOTFOUND = 2'd1,
        EC_EXISTS   = 2'd2
    } t_err;

    // Session phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_RECV = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // One received packet event
    typedef struct packed {
        t_action            action;
        logic [BLK_W-1:0]   block_number;
        logic [LEN_W-1:0]   payload_length;
        logic               file_ok;
        logic [LEN_W-1:0]   file_bytes;
    } t_item;

    // One reply
    typedef struct packed {
        t_kind              reply_kind;
        logic [BLK_W-1:0]   reply_block;
        t_err               error_code;
        logic [LEN_W-1:0]   reply_length;
        logic               write_payload;
        logic               commit_file;
    } t_result;

endpackage

/* sv/tftp_transfer_session.sv */
// Top level of the TFTP transfer session block: input register, session
// core and the reply output register. Depends on tts_pkg, tts_in_stage,
// tts_core.
//
//  channel  dir  tdata                                  tuser
//  s_axis   in   packet event (block, lengths, file_ok) packet kind
//  m_axis   out  reply (block, code, length, flags)     reply kind
//
// One beat per cycle while m_axis does not stall; each reply is registered.
// Each packet event passes the state machine, combinationally, between the input
// register and the reply register; the state update is the only feedback.
// Reset (synchronous, active low) returns the session to idle, block 0.
// A stalled m_axis holds the reply; s_axis keeps taking beats into the input
// register, then stalls once both registers are full.
module tftp_transfer_session (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] block_number, [25:16] payload_length, [26] file_ok,
    // [36:27] file_bytes, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    // [2:0] action
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] reply_block, [17:16] error_code, [27:18] reply_length,
    // [28] write_payload, [29] commit_file, [31:30] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] reply_kind
    output logic [1:0]  m_axis_tuser
);
    import tts_pkg::*;

    t_item   in_item, core_item;
    logic    core_valid, step;
    logic    res_valid;
    t_result result;

    logic    r_out_valid;
    t_result r_out;

    // Unpack the input beat
    assign in_item.action         = t_action'(s_axis_tuser);
    assign in_item.block_number   = s_axis_tdata[15:0];
    assign in_item.payload_length = s_axis_tdata[25:16];
    assign in_item.file_ok        = s_axis_tdata[26];
    assign in_item.file_bytes     = s_axis_tdata[36:27];

    // Process when the reply register is free or drains this cycle
    assign step = core_valid && (!r_out_valid || m_axis_tready);

    tts_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    tts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (core_item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // Reply valid: load on a step, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Reply payload
    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= result;
        end
    end

    // Pack the output beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.reply_kind;
    assign m_axis_tdata  = {2'b00, r_out.commit_file, r_out.write_payload,
                            r_out.reply_length, r_out.error_code, r_out.reply_block};

`ifndef SYNTHESIS
    // Payload writes only come with an ack
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.write_payload) |-> r_out.reply_kind == KIND_ACK)
        else $error("write flag on a non-ack reply");

    // Commit only with a payload write
    a_commit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.commit_file) |-> r_out.write_payload)
        else $error("commit without payload write");

    // Error replies carry no block or length
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reply_kind == KIND_ERR)
            |-> (r_out.reply_block == '0 && r_out.reply_length == '0))
        else $error("error reply with block or length set");
`endif

endmodule

/* sv/tts_in_stage.sv */
// Input register for the TFTP transfer session block.
// Captures one packet-event beat and holds it until the core takes it.
// Depends on tts_pkg.
module tts_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tts_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output tts_pkg::t_item o_item
);
    import tts_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Take a new beat when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || i_take;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/tts_core.sv */
// Session state machine of the TFTP transfer session block.
// Keeps phase, block counter and final-block flag; decides the reply.
// Depends on tts_pkg.
module tts_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  tts_pkg::t_item   i_item,
    output logic             o_res_valid,
    output tts_pkg::t_result o_result
);
    import tts_pkg::*;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(BLOCK_BYTES);

    t_phase           r_phase, n_phase;
    logic [BLK_W-1:0] r_counter, n_counter;
    logic             r_last, n_last;

    logic [BLK_W-1:0] counter_inc;
    logic [LEN_W-1:0] send_len;
    logic             send_short;

    // State registers advance only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_counter <= '0;
            r_last    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_counter <= n_counter;
            r_last    <= n_last;
        end
    end

    // Saturate the file block length and mark a short block
    assign counter_inc = r_counter + BLK_W'(1);
    assign send_short  = i_item.file_bytes < FULL_LEN;
    assign send_len    = send_short ? i_item.file_bytes : FULL_LEN;

    // Next state and reply
    always_comb begin
        n_phase     = r_phase;
        n_counter   = r_counter;
        n_last      = r_last;
        o_res_valid = 1'b1;
        o_result    = '{reply_kind: KIND_ERR, reply_block: '0, error_code: EC_ILLEGAL,
                        reply_length: '0, write_payload: 1'b0, commit_file: 1'b0};
        case (i_item.action)
            ACT_RRQ: begin
                n_phase = PH_DONE;
                if (r_phase == PH_IDLE) begin
                    if (!i_item.file_ok) begin
                        o_result.error_code = EC_NOTFOUND;
                    end else begin
                        n_phase                = PH_SEND;
                        n_counter              = BLK_W'(1);
                        n_last                 = send_short;
                        o_result.reply_kind    = KIND_DATA;
                        o_result.reply_block   = BLK_W'(1);
                        o_result.reply_length  = send_len;
                    end
                end
            end
            ACT_WRQ: begin
                n_phase = PH_DONE;
                if (r_phase == PH_IDLE) begin
                    if (!i_item.file_ok) begin
                        o_result.error_code = EC_EXISTS;
                    end else begin
                        n_phase             = PH_RECV;
                        n_counter           = '0;
                        o_result.reply_kind = KIND_ACK;
                    end
                end
            end
            ACT_DATA: begin
                if (r_phase != PH_RECV) begin
                    n_phase = PH_DONE;
                end else if (i_item.block_number != counter_inc) begin
                    // drop out-of-order data
                    o_res_valid = 1'b0;
                end else begin
                    n_counter              = counter_inc;
                    o_result.reply_kind    = KIND_ACK;
                    o_result.reply_block   = counter_inc;
                    o_result.write_payload = 1'b1;
                    o_result.commit_file   = i_item.payload_length < FULL_LEN;
                    if (i_item.payload_length < FULL_LEN) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            ACT_ACK: begin
                if (r_phase != PH_SEND) begin
                    n_phase = PH_DONE;
                end else if (i_item.block_number != r_counter) begin
                    // drop out-of-order ack
                    o_res_valid = 1'b0;
                end else if (r_last) begin
                    // final block acknowledged: close silently
                    n_phase     = PH_DONE;
                    o_res_valid = 1'b0;
                end else begin
                    n_counter             = counter_inc;
                    n_last                = send_short;
                    o_result.reply_kind   = KIND_DATA;
                    o_result.reply_block  = counter_inc;
                    o_result.reply_length = send_len;
                end
            end
            ACT_ERROR: begin
                n_phase     = PH_DONE;
                o_res_valid = 1'b0;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A finished session never reopens
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |=> r_phase == PH_DONE)
        else $error("session left the done phase");

    // An idle session has a clear counter and flag
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_counter == '0 && !r_last))
        else $error("idle session with stale counter");

    // A receiving session never carries the final-block flag
    a_recv_no_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> !r_last)
        else $error("final-block flag set while receiving");
`endif

endmodule
